FILE: hdl/winnowing_fingerprint_selector_assert.svh
// assertion macros for the winnowing fingerprint selector
// expects signals named clock and reset in the including module
`ifndef WINNOWING_FINGERPRINT_SELECTOR_ASSERT_SVH
`define WINNOWING_FINGERPRINT_SELECTOR_ASSERT_SVH

// same-cycle implication, off while reset is high
`define WFS_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define WFS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/wfs_pkg.sv
// shared types, constants and modulo tables of the winnowing fingerprint selector
// no dependencies; used by wfs_hash, wfs_cell and the top level
`default_nettype none

package wfs_pkg;

   localparam int HASH_MODULUS = 101;
   localparam int HASH_RADIX   = 256;
   localparam int HASH_W       = 7;
   localparam int BYTE_W       = 8;
   localparam int LINE_W       = 16;
   localparam int RSP_DATA_W   = 24;

   typedef logic [HASH_W-1:0] hash_type;
   typedef hash_type hash_tab_type [HASH_MODULUS];
   typedef hash_type byte_tab_type [HASH_RADIX];

   // hash of the substring ending at the current byte
   typedef struct packed {
      logic     valid;
      hash_type value;
   } hash_out_type;

   // one queued fingerprint, fingerprint in the low bits
   typedef struct packed {
      logic [LINE_W-1:0] line_number;
      hash_type          fingerprint;
   } result_type;

   // (h * radix) mod modulus for every hash value h
   function automatic hash_tab_type build_shift_tab();
      hash_tab_type t;
      for (int i = 0; i < HASH_MODULUS; i++) begin
         t[i] = HASH_W'((i * HASH_RADIX) % HASH_MODULUS);
      end
      return t;
   endfunction

   // b mod modulus for every byte b
   function automatic byte_tab_type build_byte_tab();
      byte_tab_type t;
      for (int i = 0; i < HASH_RADIX; i++) begin
         t[i] = HASH_W'(i % HASH_MODULUS);
      end
      return t;
   endfunction

   // -(b * radix^len) mod modulus, the weight of the byte leaving the substring
   function automatic byte_tab_type build_drop_tab(input int len);
      int           weight;
      byte_tab_type t;
      weight = 1;
      for (int k = 0; k < len; k++) begin
         weight = (weight * HASH_RADIX) % HASH_MODULUS;
      end
      for (int i = 0; i < HASH_RADIX; i++) begin
         t[i] = HASH_W'((i * (HASH_MODULUS - weight)) % HASH_MODULUS);
      end
      return t;
   endfunction

   localparam hash_tab_type SHIFT_TAB = build_shift_tab();
   localparam byte_tab_type BYTE_TAB  = build_byte_tab();

endpackage

`default_nettype wire

FILE: hdl/wfs_cell.sv
// one cell of the window chain: running rightmost minimum over the newest entries
// depends on wfs_pkg
`default_nettype none

module wfs_cell #(
   parameter int AGE_W = 2
) (
   input  wire logic             clock,
   input  wire logic             shift,
   input  wire wfs_pkg::hash_type hash_new,
   input  wire wfs_pkg::hash_type prev_value,
   input  wire logic [AGE_W-1:0] prev_age,
   output wfs_pkg::hash_type      value,
   output wfs_pkg::hash_type      next_value,
   output logic [AGE_W-1:0]       age
);
   import wfs_pkg::*;

   hash_type         value_ff, value_in;
   logic [AGE_W-1:0] age_ff, age_in;

   // newest hash wins ties, otherwise take the neighbor's minimum one slot older
   always_comb begin
      value_in = value_ff;
      age_in   = age_ff;
      if (shift) begin
         if (hash_new <= prev_value) begin
            value_in = hash_new;
            age_in   = '0;
         end else begin
            value_in = prev_value;
            age_in   = prev_age + AGE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      age_ff   <= age_in;
   end

   assign value      = value_ff;
   assign age        = age_ff;
   assign next_value = value_in;

endmodule

`default_nettype wire

FILE: hdl/wfs_hash.sv
// rolling substring hash: byte shift line, fill count and table-based modulo update
// depends on wfs_pkg
`default_nettype none

module wfs_hash #(
   parameter int SUBSTRING_LEN = 3
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       step,
   input  wire logic                       clear,
   input  wire logic [wfs_pkg::BYTE_W-1:0] data_byte,
   output wfs_pkg::hash_out_type           hash_out
);
   import wfs_pkg::*;

   localparam int SEEN_W = $clog2(SUBSTRING_LEN + 1);
   localparam int SUM_W  = HASH_W + 2;
   localparam byte_tab_type DROP_TAB = build_drop_tab(SUBSTRING_LEN);

   logic [BYTE_W-1:0] recent_ff [SUBSTRING_LEN];
   logic [BYTE_W-1:0] recent_in [SUBSTRING_LEN];
   hash_type          rolling_ff, rolling_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic [SUM_W-1:0]  sum;
   hash_type          hash_next;

   // shift in the new byte, drop the oldest, reduce the sum of three residues
   always_comb begin
      sum = SUM_W'(SHIFT_TAB[rolling_ff]) + SUM_W'(DROP_TAB[recent_ff[SUBSTRING_LEN-1]])
            + SUM_W'(BYTE_TAB[data_byte]);
      if (sum >= SUM_W'(2 * HASH_MODULUS)) begin
         hash_next = HASH_W'(sum - SUM_W'(2 * HASH_MODULUS));
      end else if (sum >= SUM_W'(HASH_MODULUS)) begin
         hash_next = HASH_W'(sum - SUM_W'(HASH_MODULUS));
      end else begin
         hash_next = HASH_W'(sum);
      end
   end

   // next state of shift line, hash and saturating byte count
   always_comb begin
      for (int k = SUBSTRING_LEN - 1; k > 0; k--) begin
         recent_in[k] = clear ? '0 : recent_ff[k-1];
      end
      recent_in[0] = clear ? '0 : data_byte;
      rolling_in   = clear ? '0 : hash_next;
      if (clear) begin
         seen_in = '0;
      end else if (seen_ff == SEEN_W'(SUBSTRING_LEN)) begin
         seen_in = seen_ff;
      end else begin
         seen_in = seen_ff + SEEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SUBSTRING_LEN; k++) begin
            recent_ff[k] <= '0;
         end
         rolling_ff <= '0;
         seen_ff    <= '0;
      end else if (step) begin
         recent_ff  <= recent_in;
         rolling_ff <= rolling_in;
         seen_ff    <= seen_in;
      end
   end

   // a hash exists once the current byte completes a full substring
   assign hash_out.valid = (seen_ff >= SEEN_W'(SUBSTRING_LEN - 1));
   assign hash_out.value = hash_next;

endmodule

`default_nettype wire

FILE: hdl/winnowing_fingerprint_selector.sv
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | tdata[7:0] data_byte, tlast end_of_line
// rsp     | out | rsp_tvalid/rsp_tready | tdata[6:0] fingerprint, [22:7] line_number
//
// one byte per clock while the queue has room; a fingerprint enters the output queue
// at the clock edge that takes its byte. the rate is set by the rolling hash update
// and the one-compare step of each window cell, both combinational.
// a two-word output queue keeps req ready while one result waits; req stalls only
// when both words are held.
// synchronous active-high reset clears counts, hash state and the queue; no sweep.
// top level of the winnowing fingerprint selector; uses wfs_pkg, wfs_hash, wfs_cell
`default_nettype none
`include "winnowing_fingerprint_selector_assert.svh"

module winnowing_fingerprint_selector #(
   parameter int SUBSTRING_LEN = 3,
   parameter int WINDOW_SIZE   = 4
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [wfs_pkg::BYTE_W-1:0]     req_tdata,  // [7:0] data_byte
   input  wire logic                           req_tlast,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [wfs_pkg::RSP_DATA_W-1:0]      rsp_tdata   // [6:0] fingerprint,
                                                           // [22:7] line_number
);
   import wfs_pkg::*;

   localparam int AGE_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
   localparam int FILL_W = 2;
   localparam int QUEUE_DEPTH = 2;

   logic             req_accept, rsp_pop, line_end, hash_step;
   hash_out_type     hash_out;
   hash_type         cell_value [WINDOW_SIZE];
   hash_type         cell_next  [WINDOW_SIZE];
   logic [AGE_W-1:0] cell_age   [WINDOW_SIZE];

   logic [CNT_W-1:0]  hash_count_ff, hash_count_in, count_step;
   logic [LINE_W-1:0] line_counter_ff, line_counter_in;
   logic              fill_event, steady_event, short_event, emit;
   logic [AGE_W-1:0]  sel_index;
   result_type        result_new;
   result_type        slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   assign req_accept = req_tvalid && req_tready;
   assign rsp_pop    = rsp_tvalid && rsp_tready;
   assign line_end   = req_accept && req_tlast;
   assign hash_step  = req_accept && hash_out.valid;

   // rolling hash of the newest substring
   wfs_hash #(
      .SUBSTRING_LEN(SUBSTRING_LEN)
   ) u_hash (
      .clock    (clock),
      .reset    (reset),
      .step     (req_accept),
      .clear    (req_tlast),
      .data_byte(req_tdata),
      .hash_out (hash_out)
   );

   // window chain: cell k holds the rightmost minimum of the newest k+1 hashes
   for (genvar g = 0; g < WINDOW_SIZE; g++) begin : g_cell
      hash_type         prev_value;
      logic [AGE_W-1:0] prev_age;
      if (g == 0) begin : g_head
         assign prev_value = hash_out.value;
         assign prev_age   = '0;
      end else begin : g_link
         assign prev_value = cell_value[g-1];
         assign prev_age   = cell_age[g-1];
      end
      wfs_cell #(
         .AGE_W(AGE_W)
      ) u_cell (
         .clock     (clock),
         .shift     (hash_step),
         .hash_new  (hash_out.value),
         .prev_value(prev_value),
         .prev_age  (prev_age),
         .value     (cell_value[g]),
         .next_value(cell_next[g]),
         .age       (cell_age[g])
      );
   end

   // emission decision: first full window, minimum aged out, strictly smaller hash,
   // or a short line ending
   always_comb begin
      count_step   = hash_count_ff;
      fill_event   = 1'b0;
      steady_event = 1'b0;
      if (hash_step) begin
         if (hash_count_ff == CNT_W'(WINDOW_SIZE)) begin
            steady_event = (cell_age[WINDOW_SIZE-1] == AGE_W'(WINDOW_SIZE - 1))
                           || (hash_out.value < cell_value[WINDOW_SIZE-1]);
         end else begin
            count_step = hash_count_ff + CNT_W'(1);
            fill_event = (count_step == CNT_W'(WINDOW_SIZE));
         end
      end
      short_event = line_end && (count_step != '0) && (count_step < CNT_W'(WINDOW_SIZE));
      emit        = fill_event || steady_event || short_event;
      sel_index   = short_event ? AGE_W'(count_step - CNT_W'(1)) : AGE_W'(WINDOW_SIZE - 1);
      result_new.fingerprint = cell_next[sel_index];
      result_new.line_number = line_counter_ff;
      hash_count_in   = line_end ? '0 : count_step;
      line_counter_in = line_end ? line_counter_ff + LINE_W'(1) : line_counter_ff;
   end

   // two-word output queue, slot0 is the head
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      fill_in  = fill_ff;
      case ({emit, rsp_pop})
         2'b10: begin
            if (fill_ff == '0) begin
               slot0_in = result_new;
            end else begin
               slot1_in = result_new;
            end
            fill_in = fill_ff + FILL_W'(1);
         end
         2'b01: begin
            slot0_in = slot1_ff;
            fill_in  = fill_ff - FILL_W'(1);
         end
         2'b11: begin
            if (fill_ff == FILL_W'(1)) begin
               slot0_in = result_new;
            end else begin
               slot0_in = slot1_ff;
               slot1_in = result_new;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_count_ff   <= '0;
         line_counter_ff <= '0;
         fill_ff         <= '0;
      end else begin
         hash_count_ff   <= hash_count_in;
         line_counter_ff <= line_counter_in;
         fill_ff         <= fill_in;
      end
   end

   // queue payload
   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign req_tready = (fill_ff != FILL_W'(QUEUE_DEPTH));
   assign rsp_tvalid = (fill_ff != '0);
   assign rsp_tdata  = RSP_DATA_W'(slot0_ff);

   // checks
   `WFS_ASSERT_IMPLIES(a_fingerprint_range, rsp_tvalid,
      rsp_tdata[HASH_W-1:0] < HASH_W'(HASH_MODULUS), "fingerprint not below modulus")
   `WFS_ASSERT_IMPLIES(a_count_bound, 1'b1, hash_count_ff <= CNT_W'(WINDOW_SIZE),
      "hash count beyond window size")
   `WFS_ASSERT_NEXT(a_line_end_clears, line_end, hash_count_ff == '0,
      "hash count not cleared at line end")
   `WFS_ASSERT_NEXT(a_line_holds, req_accept && !req_tlast,
      line_counter_ff == $past(line_counter_ff), "line counter moved inside a line")
   `WFS_ASSERT_IMPLIES(a_min_not_above_newest, hash_count_ff == CNT_W'(WINDOW_SIZE),
      cell_value[WINDOW_SIZE-1] <= cell_value[0], "window minimum above newest hash")

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// self-checking bench for winnowing_fingerprint_selector: streams text lines, predicts
// fingerprint words in a local model or takes them from typed directed rows, and compares them with the rsp channel
// depends on wfs_pkg and the top level RTL only
`default_nettype none

module tb_top;
   import wfs_pkg::*;

   localparam int SUB_LEN      = 3;
   localparam int WIN          = 4;
   localparam int ITEM_TARGET  = 1600;
   localparam int HOLD_AFTER   = 120;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int REPORT_MAX   = 10;

   // how a directed row gets its expectation
   typedef enum logic [1:0] {
      ROW_MODEL,
      ROW_QUIET,
      ROW_TYPED
   } row_kind_type;

   typedef struct {
      logic [BYTE_W-1:0] data;
      bit                eol;
      row_kind_type      kind;
      hash_type          fp;
      logic [LINE_W-1:0] line;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata;   // [7:0] data_byte
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [6:0] fingerprint, [22:7] line_number

   // predictor state
   hash_type          roll_hash;
   logic [BYTE_W-1:0] tail_bytes [SUB_LEN];
   int unsigned       line_bytes;
   int unsigned       line_hashes;
   hash_type          recent_hashes [WIN];
   hash_type          held_min;
   int unsigned       held_age;
   logic [LINE_W-1:0] cur_line;

   result_type  expected_fingerprints [$];
   int unsigned items_sent;
   int unsigned fingerprints_checked;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   bit          send_calm;
   bit          recv_calm;
   bit          stall_done;

   // short lines of zeros and 0xff, a falling run and a run of equal bytes
   stim_row_type directed_rows [25] = '{
      '{8'h00, 1'b0, ROW_QUIET, 7'd0, 16'd0},
      '{8'h00, 1'b0, ROW_QUIET, 7'd0, 16'd0},
      '{8'h00, 1'b1, ROW_TYPED, 7'd0, 16'd0},
      '{8'hFF, 1'b1, ROW_QUIET, 7'd0, 16'd0},
      '{8'h00, 1'b0, ROW_QUIET, 7'd0, 16'd0},
      '{8'h00, 1'b0, ROW_QUIET, 7'd0, 16'd0},
      '{8'h00, 1'b0, ROW_QUIET, 7'd0, 16'd0},
      '{8'h00, 1'b0, ROW_QUIET, 7'd0, 16'd0},
      '{8'h00, 1'b0, ROW_QUIET, 7'd0, 16'd0},
      '{8'h00, 1'b1, ROW_TYPED, 7'd0, 16'd2},
      '{8'hFF, 1'b0, ROW_QUIET, 7'd0, 16'd0},
      '{8'hFF, 1'b0, ROW_QUIET, 7'd0, 16'd0},
      '{8'hFF, 1'b1, ROW_TYPED, 7'd4, 16'd3},
      '{8'd250, 1'b0, ROW_MODEL, 7'd0, 16'd0},
      '{8'd200, 1'b0, ROW_MODEL, 7'd0, 16'd0},
      '{8'd150, 1'b0, ROW_MODEL, 7'd0, 16'd0},
      '{8'd100, 1'b0, ROW_MODEL, 7'd0, 16'd0},
      '{8'd50,  1'b0, ROW_MODEL, 7'd0, 16'd0},
      '{8'd0,   1'b1, ROW_MODEL, 7'd0, 16'd0},
      '{8'd7, 1'b0, ROW_MODEL, 7'd0, 16'd0},
      '{8'd7, 1'b0, ROW_MODEL, 7'd0, 16'd0},
      '{8'd7, 1'b0, ROW_MODEL, 7'd0, 16'd0},
      '{8'd7, 1'b0, ROW_MODEL, 7'd0, 16'd0},
      '{8'd7, 1'b0, ROW_MODEL, 7'd0, 16'd0},
      '{8'd7, 1'b1, ROW_MODEL, 7'd0, 16'd0}
   };

   winnowing_fingerprint_selector #(
      .SUBSTRING_LEN(SUB_LEN),
      .WINDOW_SIZE  (WIN)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // append one expected word at the tail of the queue
   task automatic queue_expected(input result_type w);
      expected_fingerprints = {expected_fingerprints, w};
   endtask

   // rightmost minimum among the newest n window entries
   function automatic void select_minimum(input int unsigned n);
      int unsigned p;
      p = n - 1;
      held_min = recent_hashes[p];
      held_age = p;
      while (p > 0) begin
         p--;
         if (recent_hashes[p] <= held_min) begin
            held_min = recent_hashes[p];
            held_age = p;
         end
      end
   endfunction

   // advance the model by one byte; returns 1 when a fingerprint word is due
   function automatic bit predict_fingerprint(input logic [BYTE_W-1:0] data, input bit eol,
                                              output result_type fp_out);
      int unsigned acc;
      bit          hit;
      hit = 1'b0;
      for (int k = SUB_LEN - 1; k > 0; k--) tail_bytes[k] = tail_bytes[k-1];
      tail_bytes[0] = data;
      if (line_bytes < SUB_LEN) line_bytes++;

      // rolling hash of the newest substring, then the window update
      if (line_bytes >= SUB_LEN) begin
         acc = 0;
         for (int k = SUB_LEN; k > 0; k--) begin
            acc = (acc * HASH_RADIX + tail_bytes[k-1]) % HASH_MODULUS;
         end
         roll_hash = hash_type'(acc);
         for (int k = WIN - 1; k > 0; k--) recent_hashes[k] = recent_hashes[k-1];
         recent_hashes[0] = roll_hash;
         if (line_hashes < WIN) begin
            line_hashes++;
            if (line_hashes == WIN) begin
               select_minimum(WIN);
               hit = 1'b1;
            end
         end else begin
            held_age++;
            if (held_age >= WIN) begin
               select_minimum(WIN);
               hit = 1'b1;
            end else if (roll_hash < held_min) begin
               held_min = roll_hash;
               held_age = 0;
               hit = 1'b1;
            end else if (roll_hash == held_min) begin
               held_age = 0;
            end
         end
      end

      // a line too short for a full window reports its minimum at its end
      if (eol && !hit && line_hashes > 0 && line_hashes < WIN) begin
         select_minimum(line_hashes);
         hit = 1'b1;
      end
      fp_out.fingerprint = held_min;
      fp_out.line_number = cur_line;
      if (eol) begin
         line_bytes  = 0;
         line_hashes = 0;
         roll_hash   = '0;
         for (int k = 0; k < SUB_LEN; k++) tail_bytes[k] = '0;
         cur_line    = cur_line + LINE_W'(1);
      end
      return hit;
   endfunction

   task automatic log_failure(input string what, input int want, input int got);
      error_count++;
      if (error_count <= REPORT_MAX) begin
         $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
      end
   endtask

   // offer one byte, wait for its handshake, then record what it should produce
   task automatic send_word(input logic [BYTE_W-1:0] data, input bit eol,
                            input row_kind_type kind, input result_type typed);
      int unsigned gap;
      bit          hit;
      result_type  predicted;
      gap = send_calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= eol;
      do @(posedge clock); while (!req_tready);
      hit = predict_fingerprint(data, eol, predicted);
      case (kind)
         ROW_MODEL: if (hit) queue_expected(predicted);
         ROW_TYPED: queue_expected(typed);
         default: ;
      endcase
      items_sent++;
      @(negedge clock);
      if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
   endtask

   // one line of random text: mostly short, sometimes long, sometimes from a tiny alphabet
   task automatic send_random_line();
      int unsigned len;
      bit          narrow;
      logic [BYTE_W-1:0] data;
      case ($urandom_range(0, 9))
         0, 1:    len = $urandom_range(13, 40);
         2:       len = $urandom_range(1, 3);
         default: len = $urandom_range(4, 12);
      endcase
      narrow = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
         data = narrow ? BYTE_W'($urandom_range(0, 2) + 8'h61) : BYTE_W'($urandom_range(0, 255));
         send_word(data, i == len - 1, ROW_MODEL, '0);
      end
   endtask

   // sender and end of run
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      roll_hash   = '0;
      line_bytes  = 0;
      line_hashes = 0;
      held_min    = '0;
      held_age    = 0;
      cur_line    = '0;
      for (int k = 0; k < SUB_LEN; k++) tail_bytes[k] = '0;
      for (int k = 0; k < WIN; k++) recent_hashes[k] = '0;
      items_sent  = 0;
      send_calm   = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].data, directed_rows[i].eol, directed_rows[i].kind,
                   '{line_number: directed_rows[i].line, fingerprint: directed_rows[i].fp});
      end
      while (items_sent < ITEM_TARGET) send_random_line();
      req_tvalid <= 1'b0;

      while (expected_fingerprints.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_fingerprints.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // receiver: random back-pressure plus one long hold to fill the output queue
   initial begin
      int unsigned       gap;
      result_type        want;
      hash_type          got_fp;
      logic [LINE_W-1:0] got_line;
      rsp_tready <= 1'b0;
      fingerprints_checked = 0;
      recv_calm  = 1'b0;
      stall_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = recv_calm ? 0 : $urandom_range(0, 5);
         if (!stall_done && fingerprints_checked >= HOLD_AFTER) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            stall_done = 1'b1;
         end else if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);

         // compare the word with the oldest expectation
         got_fp   = rsp_tdata[HASH_W-1:0];
         got_line = rsp_tdata[HASH_W +: LINE_W];
         if (expected_fingerprints.size() == 0) begin
            log_failure("fingerprint word with none pending", -1, int'(got_fp));
         end else begin
            want = expected_fingerprints.pop_front();
            if (got_fp !== want.fingerprint)
               log_failure("fingerprint", int'(want.fingerprint), int'(got_fp));
            if (got_line !== want.line_number)
               log_failure("line_number", int'(want.line_number), int'(got_line));
         end
         fingerprints_checked++;
         @(negedge clock);
         if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
      end
   end

endmodule

`default_nettype wire
